FILE: src/kcdd_pkg.sv
// shared types and constants for the capability descriptor decoder
// no dependencies; used by every module of the block
package kcdd_pkg;

  localparam int unsigned MapBits   = 128;
  localparam int unsigned MapRows   = 2;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned CountBits = 10;

  localparam logic [CountBits-1:0] DefaultCountReset = 10'd512;
  localparam logic [6:0]           IrqNone           = 7'h7F;
  localparam logic [WordBits-1:0]  IoPageSize        = 32'h0000_1000;

  // descriptor prefixes, top bits only
  localparam logic [3:0]  PfxIrq     = 4'hE;
  localparam logic [4:0]  PfxSyscall = 5'b11110;
  localparam logic [7:0]  PfxHandles = 8'hFE;
  localparam logic [8:0]  PfxFlags   = 9'b1111_1111_0;
  localparam logic [11:0] PfxIoMap   = 12'hFFE;
  localparam logic [10:0] PfxStatic  = 11'b1111_1111_100;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DESC  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    KIND_IRQ        = 4'd0,
    KIND_SYSCALL    = 4'd1,
    KIND_HANDLES    = 4'd2,
    KIND_FLAGS      = 4'd3,
    KIND_IO_MAP     = 4'd4,
    KIND_STATIC_PND = 4'd5,
    KIND_STATIC_MAP = 4'd6,
    KIND_MISMATCH   = 4'd7,
    KIND_MISSING    = 4'd8,
    KIND_PADDING    = 4'd9,
    KIND_UNKNOWN    = 4'd10,
    KIND_CLEARED    = 4'd11,
    KIND_READ       = 4'd12
  } kind_e;

  typedef enum logic [0:0] {
    ROW_IRQ     = 1'b0,
    ROW_SYSCALL = 1'b1
  } row_e;

  // register index on the configuration port
  localparam logic REG_DEFAULT_COUNT = 1'b0;

  typedef struct packed {
    logic                 pending;
    logic [WordBits-1:0]  first_word;
    logic [CountBits-1:0] handle_count;
    logic [WordBits-1:0]  flags;
  } dec_state_t;

  typedef struct packed {
    kind_e               kind;
    logic                map_valid;
    logic [WordBits-1:0] map_base;
    logic [WordBits-1:0] map_size;
    logic                map_ro;
  } dec_result_t;

  // masked bitmap update and row control toward the memory
  typedef struct packed {
    logic               clear;
    logic               wr_en;
    row_e               wr_row;
    logic [MapBits-1:0] wr_mask;
    logic [MapBits-1:0] wr_data;
    logic               rd_en;
    row_e               rd_row;
  } map_op_t;

endpackage

FILE: src/kcdd_decode.sv
// descriptor classifier: prefix priority decode, next scalar state, bitmap ops
// depends on kcdd_pkg
module kcdd_decode import kcdd_pkg::*; (
  input  req_e                  req_i,
  input  logic [WordBits-1:0]   desc_i,
  input  logic                  last_i,
  input  logic [2:0]            word_index_i,
  input  logic [CountBits-1:0]  default_count_i,
  input  dec_state_t            state_i,
  output dec_state_t            state_o,
  output dec_result_t           result_o,
  output map_op_t               op_o
);

  logic [MapBits-1:0]  irq_mask;
  logic [7:0]          sys_base;
  logic [MapBits-1:0]  sys_window;
  logic [MapBits-1:0]  sys_data;
  logic [WordBits-1:0] st_start;
  logic [WordBits-1:0] st_end;

  always_comb begin
    irq_mask = '0;
    for (int j = 0; j < 4; j++) begin
      if (desc_i[7*j +: 7] != IrqNone) begin
        irq_mask = irq_mask | (MapBits'(1) << desc_i[7*j +: 7]);
      end
    end
  end

  // groups 6 and 7 shift the whole window out of the map
  assign sys_base   = 8'(desc_i[26:24]) * 8'd24;
  assign sys_window = MapBits'(24'hFF_FFFF) << sys_base;
  assign sys_data   = MapBits'(desc_i[23:0]) << sys_base;

  assign st_start = {state_i.first_word[19:0], 12'h000};
  assign st_end   = {desc_i[19:0], 12'h000};

  always_comb begin
    state_o  = state_i;
    result_o = '{kind: KIND_UNKNOWN, map_valid: 1'b0, map_base: '0, map_size: '0,
                 map_ro: 1'b0};
    op_o     = '{clear: 1'b0, wr_en: 1'b0, wr_row: ROW_IRQ, wr_mask: '0, wr_data: '0,
                 rd_en: 1'b0, rd_row: row_e'(word_index_i[2])};
    case (req_i)
      REQ_CLEAR: begin
        state_o.pending      = 1'b0;
        state_o.first_word   = '0;
        state_o.handle_count = default_count_i;
        state_o.flags        = '0;
        op_o.clear           = 1'b1;
        result_o.kind        = KIND_CLEARED;
      end
      REQ_READ: begin
        op_o.rd_en    = 1'b1;
        result_o.kind = KIND_READ;
      end
      REQ_DESC: begin
        if (state_i.pending) begin
          // second word of a static range, taken whatever its prefix
          state_o.pending = 1'b0;
          if (desc_i[31:21] != state_i.first_word[31:21]) begin
            result_o.kind = KIND_MISMATCH;
          end else begin
            result_o.kind      = KIND_STATIC_MAP;
            result_o.map_valid = 1'b1;
            result_o.map_base  = st_start;
            result_o.map_size  = st_end - st_start;
            result_o.map_ro    = state_i.first_word[20];
          end
        end else if (desc_i[31:28] == PfxIrq) begin
          result_o.kind = KIND_IRQ;
          op_o.wr_en    = 1'b1;
          op_o.wr_row   = ROW_IRQ;
          op_o.wr_mask  = irq_mask;
          op_o.wr_data  = irq_mask;
        end else if (desc_i[31:27] == PfxSyscall) begin
          result_o.kind = KIND_SYSCALL;
          op_o.wr_en    = 1'b1;
          op_o.wr_row   = ROW_SYSCALL;
          op_o.wr_mask  = sys_window;
          op_o.wr_data  = sys_data;
        end else if (desc_i[31:24] == PfxHandles) begin
          result_o.kind        = KIND_HANDLES;
          state_o.handle_count = desc_i[CountBits-1:0];
        end else if (desc_i[31:23] == PfxFlags) begin
          result_o.kind = KIND_FLAGS;
          state_o.flags = desc_i;
        end else if (desc_i[31:20] == PfxIoMap) begin
          result_o.kind      = KIND_IO_MAP;
          result_o.map_valid = 1'b1;
          result_o.map_base  = {desc_i[19:0], 12'h000};
          result_o.map_size  = IoPageSize;
        end else if (desc_i[31:21] == PfxStatic) begin
          if (last_i) begin
            result_o.kind = KIND_MISSING;
          end else begin
            result_o.kind      = KIND_STATIC_PND;
            state_o.pending    = 1'b1;
            state_o.first_word = desc_i;
          end
        end else if (&desc_i) begin
          result_o.kind = KIND_PADDING;
        end else begin
          result_o.kind = KIND_UNKNOWN;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/kcdd_map_mem.sv
// bitmap store: two 128-bit rows (interrupt map, syscall mask) with masked writes,
// per-row valid bits for the clear, registered read port; depends on kcdd_pkg
module kcdd_map_mem import kcdd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  map_op_t            op_i,
  output logic [MapBits-1:0] rd_data_o,
  output logic               rd_ok_o
);

  logic [MapBits-1:0] mem_q [MapRows];
  logic [MapRows-1:0] row_valid_q, row_valid_d;
  logic [MapBits-1:0] rd_data_q;
  logic               rd_ok_q;

  always_comb begin
    row_valid_d = row_valid_q;
    if (en_i && op_i.clear) begin
      row_valid_d = '0;
    end else if (en_i && op_i.wr_en) begin
      row_valid_d[op_i.wr_row] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else begin
      row_valid_q <= row_valid_d;
    end
  end

  // a row that is not valid reads as zero, so the first write fills it whole
  always_ff @(posedge clk_i) begin
    if (en_i && op_i.wr_en) begin
      if (row_valid_q[op_i.wr_row]) begin
        mem_q[op_i.wr_row] <= (mem_q[op_i.wr_row] & ~op_i.wr_mask) |
                              (op_i.wr_data & op_i.wr_mask);
      end else begin
        mem_q[op_i.wr_row] <= op_i.wr_data & op_i.wr_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && op_i.rd_en) begin
      rd_data_q <= mem_q[op_i.rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else if (en_i && op_i.rd_en) begin
      rd_ok_q <= row_valid_q[op_i.rd_row];
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_ok_o   = rd_ok_q;

endmodule

FILE: src/kernel_capability_descriptor_decoder.sv
// top level of the capability descriptor decoder: stream ports, apb register,
// scalar decode state and output register; uses kcdd_pkg, kcdd_decode, kcdd_map_mem
//
// usage
//   slave stream: one item per request. tuser carries req_type (clear, descriptor,
//   read bitmap word), tdata the descriptor word and word_index, tlast marks the
//   final descriptor of a list. request type 3 is taken and dropped, no result.
//   master stream: one result item per request of type 0 to 2. tuser carries kind,
//   tdata the map request fields, handle table count, flags word and readback data.
//   apb: one register, default_handle_count at address 0, loaded into the handle
//   count at reset and on every clear item.
// latency and throughput
//   a result appears in the cycle after its item is accepted. one item per cycle is
//   taken as long as the receiver keeps up: the only stage is the output register,
//   and s_axis_tready stays high whenever that register is empty or being drained.
//   the bitmaps sit in a two-row memory written with a bit mask at accept time and
//   read at accept time for readback, so back-to-back items see each other in order.
// reset and stalls
//   reset empties the output register, marks both bitmap rows as zero and restores
//   the register and the scalar state. when the receiver stalls, the result holds
//   and the slave side stops after the one item in flight.
module kernel_capability_descriptor_decoder import kcdd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // descriptor[31:0], word_index[34:32], zeros
  input  logic [1:0]   s_axis_tuser,   // req_type[1:0]
  input  logic         s_axis_tlast,   // last
  // master stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // map_valid[0], map_base[32:1], map_size[64:33],
                                       // map_read_only[65], handle_table_count[75:66],
                                       // flags_word[107:76], read_data[139:108], zeros
  output logic [3:0]   m_axis_tuser,   // kind[3:0]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic                 s_acc;
  logic                 out_load;
  req_e                 req;

  logic [CountBits-1:0] dflt_count_q;
  dec_state_t           state_q, state_d;
  dec_result_t          result;
  map_op_t              op;

  logic [MapBits-1:0]   rd_row;
  logic                 rd_ok;

  // output register
  logic                 out_valid_q, out_valid_d;
  dec_result_t          out_res_q;
  logic [CountBits-1:0] out_count_q;
  logic [WordBits-1:0]  out_flags_q;
  logic [1:0]           out_word_q;
  logic [WordBits-1:0]  read_data;

  assign req           = req_e'(s_axis_tuser);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = s_acc && (req != REQ_NONE);

  // configuration register, written on the apb access cycle
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEFAULT_COUNT) ? 32'(dflt_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_count_q <= DefaultCountReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DEFAULT_COUNT)) begin
      dflt_count_q <= pwdata[CountBits-1:0];
    end
  end

  kcdd_decode u_decode (
    .req_i           (req),
    .desc_i          (s_axis_tdata[31:0]),
    .last_i          (s_axis_tlast),
    .word_index_i    (s_axis_tdata[34:32]),
    .default_count_i (dflt_count_q),
    .state_i         (state_q),
    .state_o         (state_d),
    .result_o        (result),
    .op_o            (op)
  );

  kcdd_map_mem u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (out_load),
    .op_i      (op),
    .rd_data_o (rd_row),
    .rd_ok_o   (rd_ok)
  );

  // scalar state: pending static word, handle count, flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{pending: 1'b0, first_word: '0, handle_count: DefaultCountReset,
                   flags: '0};
    end else if (out_load) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q   <= result;
      out_count_q <= state_d.handle_count;
      out_flags_q <= state_d.flags;
      out_word_q  <= s_axis_tdata[33:32];
    end
  end

  // readback word comes straight off the memory's read register
  assign read_data = ((out_res_q.kind == KIND_READ) && rd_ok) ?
                     rd_row[out_word_q*WordBits +: WordBits] : '0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tdata  = {4'b0000, read_data, out_flags_q, out_count_q, out_res_q.map_ro,
                          out_res_q.map_size, out_res_q.map_base, out_res_q.map_valid};

endmodule

FILE: src/kcdd_checker.sv
// port-level checks for the capability descriptor decoder, bound to the top level
// depends on kcdd_pkg and kernel_capability_descriptor_decoder
module kcdd_checker import kcdd_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [3:0]   m_axis_tuser
);

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // a clear item yields a cleared result with the flags word at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_CLEAR) |=>
    m_axis_tvalid && (m_axis_tuser == KIND_CLEARED) && (m_axis_tdata[107:76] == '0) &&
    !m_axis_tdata[0])
    else $error("clear result wrong");

  // only mapping kinds report a map request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
    (m_axis_tuser == KIND_IO_MAP) || (m_axis_tuser == KIND_STATIC_MAP))
    else $error("map request on a non-mapping kind");

endmodule

bind kernel_capability_descriptor_decoder kcdd_checker u_kcdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
